>>> rtl/fdsf_pkg.sv
`timescale 1ns / 1ps

package fdsf_pkg;

  // fixed widths of the register port and of the payload fields
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned X_W       = 9;
  localparam int unsigned Y_W       = 9;
  localparam int unsigned LEN_W     = 10;

  // register reset values
  localparam int unsigned WIDTH_RST  = 320;
  localparam int unsigned HEIGHT_RST = 240;

  // depth of the queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef enum logic {
    KIND_SPAN  = 1'b0,
    KIND_FRAME = 1'b1
  } kind_e;

  // one queued event: an optional span and an optional frame-complete mark
  typedef struct packed {
    logic             has_span;
    logic             frame_end;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [LEN_W-1:0] len;
  } evt_t;

endpackage

>>> rtl/fdsf_if.sv
`timescale 1ns / 1ps

interface fdsf_pix_if;
  logic                         valid;
  logic                         ready;
  logic [fdsf_pkg::PIX_W-1:0]   new_pixel;
  logic [fdsf_pkg::PIX_W-1:0]   old_pixel;

  modport source (output valid, output new_pixel, output old_pixel, input ready);
  modport sink (input valid, input new_pixel, input old_pixel, output ready);
endinterface

interface fdsf_span_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [fdsf_pkg::X_W-1:0]     span_x;
  logic [fdsf_pkg::Y_W-1:0]     span_y;
  logic [fdsf_pkg::LEN_W-1:0]   span_len;
  logic                         last;

  modport source (output valid, output kind, output span_x, output span_y,
                  output span_len, output last, input ready);
  modport sink (input valid, input kind, input span_x, input span_y,
                input span_len, input last, output ready);
endinterface

>>> rtl/frame_diff_span_finder_unit.sv
`timescale 1ns / 1ps

// dirty-span finder: takes (new, old) pixel pairs in raster order, one request
// per clock, cuts each row into words of WORD_PIXELS pixels and reports every
// run of words holding a difference as x, y and length, from the first to the
// last differing pixel of the run; after the frame's last pixel a
// frame-complete result with last set follows. a pixel is taken every cycle
// while the 4-entry event queue between the pixel front end and the result
// back end has room; the back end sends one result per cycle while span.ready
// is high, so a span closing on the frame's last pixel gives two results. with
// rows of two or more pixels there are never more results than pixels, and
// the queue absorbs the bursts at one pixel per clock while results are
// taken; rows of a single pixel can raise more results than pixels, and then
// the result side sets the pace. results pass the queue and an output register.
// width and height are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT when written
module frame_diff_span_finder_unit #(
  parameter int unsigned MAX_WIDTH   = 512,
  parameter int unsigned MAX_HEIGHT  = 512,
  parameter int unsigned WORD_PIXELS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fdsf_pix_if.sink                         pix,
  fdsf_span_if.source                      span,
  input  logic                             cfg_we_i,
  input  logic [fdsf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fdsf_pkg::CFG_W-1:0]       cfg_data_i
);

  // column and row counter widths
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  // compare widths for clamping the written value
  localparam int unsigned DW = (CW + 1 > fdsf_pkg::CFG_W) ? CW + 1 : fdsf_pkg::CFG_W;
  localparam int unsigned DH = (RW + 1 > fdsf_pkg::CFG_W) ? RW + 1 : fdsf_pkg::CFG_W;

  localparam int unsigned W_RST =
    (fdsf_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : fdsf_pkg::WIDTH_RST;
  localparam int unsigned H_RST =
    (fdsf_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : fdsf_pkg::HEIGHT_RST;
  localparam logic [CW-1:0] WM1_RST = CW'(W_RST - 1);
  localparam logic [RW-1:0] HM1_RST = RW'(H_RST - 1);

  // width and height are kept as last column / last row, already clamped
  logic [CW-1:0] wm1_q, wm1_d;
  logic [RW-1:0] hm1_q, hm1_d;
  logic [DW-1:0] wval;
  logic [DH-1:0] hval;

  assign wval = DW'(cfg_data_i);
  assign hval = DH'(cfg_data_i);

  always_comb begin
    wm1_d = wm1_q;
    hm1_d = hm1_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdsf_pkg::CFG_FRAME_WIDTH: begin
          if (wval == '0) begin
            wm1_d = '0;
          end else if (wval > DW'(MAX_WIDTH)) begin
            wm1_d = CW'(MAX_WIDTH - 1);
          end else begin
            wm1_d = CW'(wval - 1'b1);
          end
        end
        fdsf_pkg::CFG_FRAME_HEIGHT: begin
          if (hval == '0) begin
            hm1_d = '0;
          end else if (hval > DH'(MAX_HEIGHT)) begin
            hm1_d = RW'(MAX_HEIGHT - 1);
          end else begin
            hm1_d = RW'(hval - 1'b1);
          end
        end
        default: begin
          wm1_d = wm1_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= WM1_RST;
      hm1_q <= HM1_RST;
    end else begin
      wm1_q <= wm1_d;
      hm1_q <= hm1_d;
    end
  end

  // front end: pixel compare, word and run tracking, event generation
  logic           push;
  logic           full;
  logic           pop;
  logic           evt_valid;
  fdsf_pkg::evt_t evt_in;
  fdsf_pkg::evt_t evt_head;

  fdsf_front #(
    .CW          (CW),
    .RW          (RW),
    .WORD_PIXELS (WORD_PIXELS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix    (pix),
    .wm1_i  (wm1_q),
    .hm1_i  (hm1_q),
    .full_i (full),
    .push_o (push),
    .evt_o  (evt_in)
  );

  // event queue decoupling the pixel side from the result side
  fdsf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (evt_in),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (evt_valid),
    .head_o      (evt_head)
  );

  // back end: expands each event into one or two registered results
  fdsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_valid),
    .evt_i       (evt_head),
    .pop_o       (pop),
    .span        (span)
  );

endmodule

>>> rtl/fdsf_front.sv
`timescale 1ns / 1ps

module fdsf_front #(
  parameter int unsigned CW          = 9,
  parameter int unsigned RW          = 9,
  parameter int unsigned WORD_PIXELS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fdsf_pix_if.sink         pix,
  input  logic [CW-1:0]    wm1_i,
  input  logic [RW-1:0]    hm1_i,
  input  logic             full_i,
  output logic             push_o,
  output fdsf_pkg::evt_t   evt_o
);

  localparam int unsigned WPW = (WORD_PIXELS > 1) ? $clog2(WORD_PIXELS) : 1;
  localparam logic [WPW-1:0] WP_LAST = WPW'(WORD_PIXELS - 1);

  logic [CW-1:0]  column_q, column_d;
  logic [RW-1:0]  row_q, row_d;
  logic [WPW-1:0] wpos_q, wpos_d;
  logic           run_open_q, run_open_d;
  logic           word_dirty_q, word_dirty_d;
  logic [CW-1:0]  first_q, first_d;
  logic [CW-1:0]  last_q, last_d;

  logic           accept;
  logic           diff;
  logic           row_end;
  logic           frame_end;
  logic           word_end;
  logic           dirty;
  logic           emit;
  logic [CW:0]    len;

  assign pix.ready = !full_i;
  assign accept    = pix.valid && !full_i;

  assign diff      = pix.new_pixel != pix.old_pixel;
  assign row_end   = column_q >= wm1_i;
  assign frame_end = row_end && (row_q >= hm1_i);
  assign word_end  = row_end || (wpos_q == WP_LAST);
  assign dirty     = word_dirty_q || diff;

  always_comb begin
    first_d      = first_q;
    last_d       = last_q;
    run_open_d   = run_open_q;
    word_dirty_d = dirty;
    emit         = 1'b0;
    if (diff) begin
      if (!run_open_q && !word_dirty_q) begin
        first_d = column_q;
      end
      last_d = column_q;
    end
    if (word_end) begin
      if (dirty) begin
        run_open_d = 1'b1;
      end else if (run_open_q) begin
        emit       = 1'b1;
        run_open_d = 1'b0;
      end
      word_dirty_d = 1'b0;
    end
    if (row_end && run_open_d) begin
      emit       = 1'b1;
      run_open_d = 1'b0;
    end

    if (row_end) begin
      column_d = '0;
      row_d    = frame_end ? '0 : row_q + 1'b1;
    end else begin
      column_d = column_q + 1'b1;
      row_d    = row_q;
    end
    wpos_d = word_end ? '0 : wpos_q + 1'b1;
  end

  assign len = {1'b0, last_d} - {1'b0, first_d} + 1'b1;

  always_comb begin
    evt_o.has_span  = emit;
    evt_o.frame_end = frame_end;
    evt_o.x         = fdsf_pkg::X_W'(first_d);
    evt_o.y         = fdsf_pkg::Y_W'(row_q);
    evt_o.len       = fdsf_pkg::LEN_W'(len);
  end

  assign push_o = accept && (emit || frame_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q     <= '0;
      row_q        <= '0;
      wpos_q       <= '0;
      run_open_q   <= 1'b0;
      word_dirty_q <= 1'b0;
      first_q      <= '0;
      last_q       <= '0;
    end else if (accept) begin
      column_q     <= column_d;
      row_q        <= row_d;
      wpos_q       <= wpos_d;
      run_open_q   <= run_open_d;
      word_dirty_q <= word_dirty_d;
      first_q      <= first_d;
      last_q       <= last_d;
    end
  end

endmodule

>>> rtl/fdsf_fifo.sv
`timescale 1ns / 1ps

module fdsf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fdsf_pkg::evt_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fdsf_pkg::evt_t head_o
);

  fdsf_pkg::evt_t                mem_q [fdsf_pkg::QDEPTH];
  logic [fdsf_pkg::QAW-1:0]      wr_q;
  logic [fdsf_pkg::QAW-1:0]      rd_q;
  logic [fdsf_pkg::QAW:0]        cnt_q;

  assign full_o  = cnt_q == (fdsf_pkg::QAW+1)'(fdsf_pkg::QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/fdsf_back.sv
`timescale 1ns / 1ps

module fdsf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           evt_valid_i,
  input  fdsf_pkg::evt_t evt_i,
  output logic           pop_o,
  fdsf_span_if.source    span
);

  logic                        valid_q, valid_d;
  logic                        second_q, second_d;
  fdsf_pkg::kind_e             kind_q, kind_d;
  logic [fdsf_pkg::X_W-1:0]    x_q, x_d;
  logic [fdsf_pkg::Y_W-1:0]    y_q, y_d;
  logic [fdsf_pkg::LEN_W-1:0]  len_q, len_d;
  logic                        last_q, last_d;
  logic                        load;
  logic                        take;

  assign load = !valid_q || span.ready;
  assign take = load && evt_valid_i;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    kind_d   = kind_q;
    x_d      = x_q;
    y_d      = y_q;
    len_d    = len_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = evt_valid_i;
    end
    if (take) begin
      if (evt_i.has_span && !second_q) begin
        // span first; a frame-complete mark on the same event follows next
        kind_d   = fdsf_pkg::KIND_SPAN;
        x_d      = evt_i.x;
        y_d      = evt_i.y;
        len_d    = evt_i.len;
        last_d   = !evt_i.frame_end;
        second_d = evt_i.frame_end;
        pop_o    = !evt_i.frame_end;
      end else begin
        kind_d   = fdsf_pkg::KIND_FRAME;
        x_d      = '0;
        y_d      = '0;
        len_d    = '0;
        last_d   = 1'b1;
        second_d = 1'b0;
        pop_o    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    x_q    <= x_d;
    y_q    <= y_d;
    len_q  <= len_d;
    last_q <= last_d;
  end

  assign span.valid    = valid_q;
  assign span.kind     = kind_q;
  assign span.span_x   = x_q;
  assign span.span_y   = y_q;
  assign span.span_len = len_q;
  assign span.last     = last_q;

endmodule
